@@ src/tks_pkg.sv @@
package tks_pkg;

    localparam int KEY_W  = 32;
    localparam int ACT_W  = 2;
    localparam int MODE_W = 2;
    localparam int POS_W  = 11;

    // action codes carried in s_tuser
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;

    // search_mode codes; the unused code behaves as forward
    localparam logic [MODE_W-1:0] MODE_FORWARD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BACKWARD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BINARY   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } seq_state_t;

    // search request from the top level to the sequencer
    typedef struct packed {
        logic              start;
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
    } tks_cmd_t;

    // sequencer status and result
    typedef struct packed {
        logic             idle;
        logic             done;
        logic             found;
        logic [POS_W-1:0] pos;
    } tks_stat_t;

endpackage

@@ src/tks_key_ram.sv @@
module tks_key_ram
    import tks_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [KEY_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [KEY_W-1:0]  rd_data
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/tks_search_seq.sv @@
module tks_search_seq
    import tks_pkg::*;
#(
    parameter int CNT_W  = 11,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tks_cmd_t          cmd,
    input  logic [CNT_W-1:0]  entry_count,
    input  logic              out_free,
    output tks_stat_t         stat,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [KEY_W-1:0]  rd_data
);

    seq_state_t state_reg, state_next;

    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  pend_pos_reg, pend_pos_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic              found_reg, found_next;
    logic [CNT_W-1:0]  res_pos_reg, res_pos_next;

    logic              in_range;
    logic              hit;
    logic              key_lt;
    logic              is_bin;
    logic              is_bwd;
    logic              scan_end;
    logic [CNT_W:0]    mid_sum;
    logic [CNT_W-1:0]  mid;
    logic [CNT_W-1:0]  probe_pos;
    logic [CNT_W-1:0]  probe_addr;
    logic [POS_W+CNT_W-1:0] pos_ext;

    // shared compare unit: equality and signed order against the probe read
    assign hit    = pend_reg && (rd_data == key_reg);
    assign key_lt = $signed(key_reg) < $signed(rd_data);

    assign is_bin   = (mode_reg == MODE_BINARY);
    assign is_bwd   = (mode_reg == MODE_BACKWARD);
    assign in_range = (lo_reg <= hi_reg);
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[CNT_W:1];

    // no match and nothing left to probe
    assign scan_end = !hit && (is_bin ? (!pend_reg && !in_range) : !in_range);

    // next position to read
    always_comb begin
        if (is_bin) begin
            probe_pos = mid;
        end else if (is_bwd) begin
            probe_pos = hi_reg;
        end else begin
            probe_pos = lo_reg;
        end
    end

    assign probe_addr = probe_pos - CNT_W'(1);
    assign rd_addr    = probe_addr[ADDR_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit || scan_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and read control
    always_comb begin
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        pend_next     = 1'b0;
        pend_pos_next = pend_pos_reg;
        key_next      = key_reg;
        mode_next     = mode_reg;
        found_next    = found_reg;
        res_pos_next  = res_pos_reg;
        rd_en         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    lo_next   = CNT_W'(1);
                    hi_next   = entry_count;
                    key_next  = cmd.key;
                    mode_next = cmd.mode;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    found_next   = 1'b1;
                    res_pos_next = pend_pos_reg;
                end else if (scan_end) begin
                    found_next   = 1'b0;
                    res_pos_next = '0;
                end else if (is_bin) begin
                    if (pend_reg) begin
                        // narrow the window around the probe just compared
                        if (key_lt) begin
                            hi_next = pend_pos_reg - CNT_W'(1);
                        end else begin
                            lo_next = pend_pos_reg + CNT_W'(1);
                        end
                    end else begin
                        rd_en         = 1'b1;
                        pend_next     = 1'b1;
                        pend_pos_next = probe_pos;
                    end
                end else begin
                    // linear: one read per cycle; each read is compared once the RAM has registered its data
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_pos_next = probe_pos;
                    if (is_bwd) begin
                        hi_next = hi_reg - CNT_W'(1);
                    end else begin
                        lo_next = lo_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        pend_pos_reg <= pend_pos_next;
        key_reg      <= key_next;
        mode_reg     <= mode_next;
        found_reg    <= found_next;
        res_pos_reg  <= res_pos_next;
    end

    // position is reported in its low bits only
    assign pos_ext = {{POS_W{1'b0}}, res_pos_reg};

    assign stat.idle  = (state_reg == ST_IDLE);
    assign stat.done  = (state_reg == ST_DONE);
    assign stat.found = found_reg;
    assign stat.pos   = pos_ext[POS_W-1:0];

endmodule

@@ src/table_key_search_unit.sv @@
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata[31:0] key_value, s_tuser[1:0] action
// m_        out  m_tvalid/m_tready  m_tdata[10:0] position, m_tuser[0] found
// cfg_      in   cfg_wr_en          cfg_wr_data[1:0] search_mode
//
// A linear search reads one entry per cycle through the single RAM read
// port and stops early on a match. A binary search reads each probe, then
// compares it and narrows the window around it.
// Reset clears the entry count and search_mode; table contents are undefined.
// Results sit in an output register, so the next item is taken while a result
// waits; a search finishing into a full output register holds until it drains.
module table_key_search_unit
    import tks_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,     // [31:0] key_value
    input  logic [1:0]        s_tuser,     // [1:0] action
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,     // [10:0] position, [15:11] zero
    output logic [0:0]        m_tuser,     // [0] found
    input  logic              cfg_wr_en,
    input  logic [MODE_W-1:0] cfg_wr_data
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 2);

    logic [MODE_W-1:0] mode_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_found_reg;
    logic [POS_W-1:0]  m_pos_reg;

    logic              s_acc;
    logic              out_free;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [KEY_W-1:0]  rd_data;
    tks_cmd_t          cmd;
    tks_stat_t         stat;

    assign s_tready = stat.idle;
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_FORWARD;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    // clear and append update the entry count; full table ignores appends
    assign wr_en = s_acc && (s_tuser == ACT_APPEND) && (count_reg < CNT_W'(TABLE_DEPTH));

    always_comb begin
        count_next = count_reg;
        if (s_acc && (s_tuser == ACT_CLEAR)) begin
            count_next = '0;
        end else if (wr_en) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign cmd.start = s_acc && (s_tuser == ACT_SEARCH);
    assign cmd.mode  = mode_reg;
    assign cmd.key   = s_tdata;

    tks_key_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tks_search_seq #(
        .CNT_W  (CNT_W),
        .ADDR_W (ADDR_W)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .entry_count (count_reg),
        .out_free    (out_free),
        .stat        (stat),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (stat.done && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stat.done && out_free) begin
            m_found_reg <= stat.found;
            m_pos_reg   <= stat.pos;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16 - POS_W){1'b0}}, m_pos_reg};
    assign m_tuser  = m_found_reg;

    // entry count stays within the table
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // a miss always reports position zero
    a_miss_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 16'd0))
        else $error("miss with nonzero position");

    // a search keeps the input closed in the following cycle
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == ACT_SEARCH)) |=> !s_tready)
        else $error("input open right after a search was taken");

endmodule

@@ dv/table_key_search_unit_tb.sv @@
`timescale 1ns / 100ps

module table_key_search_unit_tb;
    import tks_pkg::*;

    localparam int DEPTH     = 1024;
    localparam int TAIL_WAIT = 64;
    localparam int IDLE_PCT  = 18;

    // codes the package leaves unnamed
    localparam logic [ACT_W-1:0]  ACT_UNUSED  = 2'd3;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic             found;
        logic [POS_W-1:0] pos;
    } hit_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata = '0;
    logic [1:0]        s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;
    logic [0:0]        m_tuser;
    logic              cfg_wr_en = 1'b0;
    logic [MODE_W-1:0] cfg_wr_data = '0;

    // shadow copy of the block's table and mode
    logic signed [KEY_W-1:0] shadow_keys [DEPTH];
    int                      shadow_count = 0;
    logic [MODE_W-1:0]       shadow_mode = MODE_FORWARD;

    hit_t hit_q[$];
    hit_t head_hit;

    int  errors = 0;
    int  items_sent = 0;
    int  hits_checked = 0;
    int  stall_left = 0;
    bit  no_idle = 1'b0;

    table_key_search_unit #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // position of the key under the current mode, 0 when absent
    function automatic int lookup_pos(input logic signed [KEY_W-1:0] key);
        int lo;
        int hi;
        int mid;
        case (shadow_mode)
            MODE_BACKWARD: begin
                for (int i = shadow_count; i >= 1; i--)
                    if (shadow_keys[i-1] == key) return i;
            end
            MODE_BINARY: begin
                lo = 1;
                hi = shadow_count;
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (shadow_keys[mid-1] == key) return mid;
                    if (key < shadow_keys[mid-1]) hi = mid - 1;
                    else lo = mid + 1;
                end
            end
            default: begin
                for (int i = 1; i <= shadow_count; i++)
                    if (shadow_keys[i-1] == key) return i;
            end
        endcase
        return 0;
    endfunction

    // update the shadow table for an accepted item; queue the hit of a search
    task automatic apply_to_table(input logic [ACT_W-1:0] act,
                                  input logic signed [KEY_W-1:0] key);
        hit_t h;
        int   p;
        case (act)
            ACT_CLEAR: shadow_count = 0;
            ACT_APPEND: begin
                if (shadow_count < DEPTH) begin
                    shadow_keys[shadow_count] = key;
                    shadow_count++;
                end
            end
            ACT_SEARCH: begin
                p = lookup_pos(key);
                h.found = (p != 0);
                h.pos = p[POS_W-1:0];
                hit_q.push_back(h);
            end
            default: ;
        endcase
    endtask

    // offer one item, return at the edge that accepts it with valid left high
    task automatic send_item(input logic [ACT_W-1:0] act,
                             input logic signed [KEY_W-1:0] key);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= key;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        apply_to_table(act, key);
    endtask

    // stop sending and wait until every queued hit has come out
    task automatic drain_hits();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (hit_q.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
    endtask

    // only called with the block idle
    task automatic set_mode(input logic [MODE_W-1:0] mode);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        shadow_mode = mode;
        @(posedge aclk);
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(3))
            0: return $urandom;
            1: begin
                case ($urandom_range(3))
                    0: return KEY_MIN;
                    1: return KEY_MAX;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return int'($urandom_range(16)) - 8;
        endcase
    endfunction

    // output side: random ready, a counted hold-off on request, hit checker
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (hit_q.size() == 0) begin
                $error("unexpected result: found %0d position %0d",
                       m_tuser[0], m_tdata[POS_W-1:0]);
                errors++;
            end else begin
                head_hit = hit_q.pop_front();
                hits_checked++;
                if (m_tuser[0] !== head_hit.found) begin
                    $error("found: expected %0d, actual %0d", head_hit.found, m_tuser[0]);
                    errors++;
                end
                if (m_tdata[POS_W-1:0] !== head_hit.pos) begin
                    $error("position: expected %0d, actual %0d",
                           head_hit.pos, m_tdata[POS_W-1:0]);
                    errors++;
                end
                if (m_tdata[15:POS_W] !== '0) begin
                    $error("tdata pad: expected 0, actual %0h", m_tdata[15:POS_W]);
                    errors++;
                end
            end
        end
    end

    // extremes, duplicates, empty table and the unused action, at reset mode
    task automatic test_directed();
        send_item(ACT_SEARCH, 32'sd0);
        send_item(ACT_APPEND, KEY_MIN);
        send_item(ACT_APPEND, KEY_MAX);
        send_item(ACT_APPEND, 32'sd0);
        send_item(ACT_APPEND, -32'sd1);
        send_item(ACT_APPEND, KEY_MAX);
        send_item(ACT_SEARCH, KEY_MAX);
        send_item(ACT_SEARCH, KEY_MIN);
        send_item(ACT_SEARCH, -32'sd1);
        send_item(ACT_SEARCH, 32'sd5);
        send_item(ACT_UNUSED, 32'sd5);
        send_item(ACT_SEARCH, 32'sd0);
        send_item(ACT_CLEAR, 32'sd0);
        send_item(ACT_SEARCH, KEY_MAX);
        send_item(ACT_APPEND, 32'sd7);
        send_item(ACT_SEARCH, 32'sd7);
        drain_hits();
    endtask

    // each mode code over a sorted table with runs of equal keys and an unsorted one
    task automatic test_modes();
        int sorted_keys[$];
        int mixed_keys[$];
        int probes[$];
        sorted_keys = '{-100, -5, -5, 0, 3, 3, 3, 42, 32'h7fff_ffff};
        mixed_keys = '{9, 1, 5, 3};
        probes = '{-5, 3, 32'h7fff_ffff, -100, 1, 32'h8000_0000, 42};
        for (int m = 0; m < 4; m++) begin
            set_mode(m[MODE_W-1:0]);
            send_item(ACT_CLEAR, $urandom);
            foreach (sorted_keys[i]) send_item(ACT_APPEND, sorted_keys[i]);
            foreach (probes[i]) send_item(ACT_SEARCH, probes[i]);
            send_item(ACT_CLEAR, $urandom);
            foreach (mixed_keys[i]) send_item(ACT_APPEND, mixed_keys[i]);
            send_item(ACT_SEARCH, 32'sd5);
            send_item(ACT_SEARCH, 32'sd9);
            send_item(ACT_SEARCH, 32'sd1);
            send_item(ACT_SEARCH, 32'sd4);
            drain_hits();
        end
    endtask

    // fill the table to the last entry, one append past it, worst-case searches
    task automatic test_full_table();
        no_idle = 1'b1;
        set_mode(MODE_BINARY);
        send_item(ACT_CLEAR, 32'sd0);
        for (int i = 0; i < DEPTH; i++) send_item(ACT_APPEND, i * 2 - 1000);
        send_item(ACT_APPEND, 32'sd12345);
        send_item(ACT_SEARCH, -32'sd1000);
        send_item(ACT_SEARCH, (DEPTH - 1) * 2 - 1000);
        send_item(ACT_SEARCH, (DEPTH / 2) * 2 - 1000);
        send_item(ACT_SEARCH, 32'sd12345);
        send_item(ACT_SEARCH, -32'sd999);
        no_idle = 1'b0;
        drain_hits();
        set_mode(MODE_FORWARD);
        send_item(ACT_SEARCH, (DEPTH - 1) * 2 - 1000);
        send_item(ACT_SEARCH, 32'sd12345);
        drain_hits();
        set_mode(MODE_BACKWARD);
        send_item(ACT_SEARCH, -32'sd1000);
        send_item(ACT_SEARCH, 32'sd0);
        drain_hits();
    endtask

    // long hold-off on the output while searches keep coming, then a full pause
    task automatic test_output_stall();
        set_mode(MODE_FORWARD);
        send_item(ACT_CLEAR, 32'sd0);
        for (int i = 0; i < 4; i++) send_item(ACT_APPEND, i);
        stall_left = 300;
        for (int i = 0; i < 20; i++) send_item(ACT_SEARCH, $urandom_range(5));
        drain_hits();
    endtask

    // random runs: mostly clear, fill, search; some loose noise items
    task automatic test_random();
        int count;
        int n_fill;
        int n_probe;
        int fill[$];
        logic [ACT_W-1:0] act;
        count = 0;
        while (count < 480) begin
            set_mode(MODE_W'($urandom_range(3)));
            no_idle = (count >= 200 && count < 260);
            if ($urandom_range(99) < 80) begin
                if ($urandom_range(19) == 0) n_fill = $urandom_range(200, 60);
                else n_fill = $urandom_range(16);
                fill.delete();
                for (int i = 0; i < n_fill; i++) fill.push_back(pick_key());
                if ((shadow_mode == MODE_BINARY) ? ($urandom_range(99) < 85)
                                                 : ($urandom_range(1) == 1))
                    fill.sort();
                send_item(ACT_CLEAR, $urandom);
                foreach (fill[i]) send_item(ACT_APPEND, fill[i]);
                n_probe = $urandom_range(8, 1);
                for (int i = 0; i < n_probe; i++) begin
                    if (n_fill > 0 && $urandom_range(1) == 1)
                        send_item(ACT_SEARCH, fill[$urandom_range(n_fill - 1)]);
                    else
                        send_item(ACT_SEARCH, pick_key());
                end
                count += 1 + n_fill + n_probe;
            end else begin
                for (int i = 0; i < 10; i++) begin
                    act = ACT_W'($urandom_range(3));
                    send_item(act, pick_key());
                    count++;
                end
            end
            drain_hits();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_modes();
        test_full_table();
        test_output_stall();
        test_random();
        drain_hits();
        $display("Sent %0d items and checked %0d search results", items_sent, hits_checked);
        $display("over all mode codes, a full table, an output hold-off and random runs.");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
